[rtl/core/nli_pkg.sv]
// Package for the thermistor table interpolator.
// Word types, table constants and helper functions; depends on nothing.
package nli_pkg;

    localparam int TABLE_POINTS        = 16;
    localparam int COUNT_FRACTION_BITS = 4;

    localparam int ADC_W  = 12;
    localparam int SUP_W  = 12;
    localparam int REF_W  = 13;
    localparam int TEMP_W = 17;
    localparam int PROD_W = ADC_W + REF_W;
    localparam int DIVD_W = PROD_W + COUNT_FRACTION_BITS;
    localparam int PT_W   = 12 + COUNT_FRACTION_BITS;
    localparam int IDX_W  = $clog2(TABLE_POINTS);
    localparam int Q2_W   = 12;
    localparam int NUM_W  = PT_W + Q2_W;
    localparam int Q_DEPTH = 4;
    localparam int QP_W   = $clog2(Q_DEPTH);

    localparam int FIRST_TEMP_DEG = -20;
    localparam int STEP_TEMP_DEG  = 10;
    localparam int STEP_Q8        = STEP_TEMP_DEG * 256;
    localparam logic [REF_W-1:0] REF_RESET = REF_W'(3300);

    localparam logic [11:0] BREAK_COUNTS [TABLE_POINTS] = '{
        12'd234,  12'd377,  12'd576,  12'd833,  12'd1141, 12'd1484, 12'd1840, 12'd2187,
        12'd2506, 12'd2786, 12'd3025, 12'd3223, 12'd3384, 12'd3515, 12'd3619, 12'd3703
    };

    typedef struct packed {
        logic [ADC_W-1:0] adc_count;
        logic [SUP_W-1:0] supply_mv;
    } t_in_word;

    typedef struct packed {
        logic signed [TEMP_W-1:0] temperature_q8;
        logic                     clamped_low;
        logic                     clamped_high;
    } t_out_word;

    // front-to-back queue entry: one division left to do
    typedef struct packed {
        logic [NUM_W-1:0]         num;
        logic [PT_W-1:0]          den;
        logic signed [TEMP_W-1:0] base;
        logic                     low;
        logic                     high;
    } t_q_entry;

    function automatic logic [PT_W-1:0] pt_q(input logic [IDX_W-1:0] idx);
        pt_q = PT_W'(BREAK_COUNTS[idx]) << COUNT_FRACTION_BITS;
    endfunction

    function automatic logic signed [TEMP_W-1:0] seg_temp(input logic [IDX_W-1:0] idx);
        seg_temp = TEMP_W'((FIRST_TEMP_DEG + STEP_TEMP_DEG * int'(idx)) * 256);
    endfunction

    localparam logic signed [TEMP_W-1:0] TEMP_LOW  = seg_temp(IDX_W'(0));
    localparam logic signed [TEMP_W-1:0] TEMP_HIGH = seg_temp(IDX_W'(TABLE_POINTS - 1));

endpackage

[rtl/core/nli_front.sv]
// Front end: rescale multiply, pipelined count/supply divider, clamp and segment search.
// Depends on nli_pkg.
module nli_front import nli_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_valid,
    input  t_in_word         i_word,
    input  logic [REF_W-1:0] i_nom_ref,
    output logic             o_last_vld,
    output t_q_entry         o_entry
);

    logic              r_a_vld;
    logic [PROD_W-1:0] r_a_prod;
    logic [SUP_W-1:0]  r_a_sup;

    logic              dv_vld  [DIVD_W+1];
    logic [SUP_W-1:0]  dv_rem  [DIVD_W+1];
    logic [DIVD_W-1:0] dv_dvd  [DIVD_W+1];
    logic [DIVD_W-1:0] dv_q    [DIVD_W+1];
    logic [SUP_W-1:0]  dv_sup  [DIVD_W+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
        end else if (i_en) begin
            r_a_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_prod <= PROD_W'(i_word.adc_count) * PROD_W'(i_nom_ref);
            r_a_sup  <= i_word.supply_mv;
        end
    end

    assign dv_vld[0] = r_a_vld;
    assign dv_rem[0] = '0;
    assign dv_dvd[0] = DIVD_W'(r_a_prod) << COUNT_FRACTION_BITS;
    assign dv_q[0]   = '0;
    assign dv_sup[0] = r_a_sup;

    // one quotient bit per stage, restoring
    for (genvar s = 0; s < DIVD_W; s++) begin : g_div
        logic [SUP_W:0] trial;
        logic           ge;
        assign trial = {dv_rem[s], dv_dvd[s][DIVD_W-1]};
        assign ge    = trial >= {1'b0, dv_sup[s]};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                dv_vld[s+1] <= 1'b0;
            end else if (i_en) begin
                dv_vld[s+1] <= dv_vld[s];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                dv_rem[s+1] <= ge ? SUP_W'(trial - {1'b0, dv_sup[s]}) : SUP_W'(trial);
                dv_dvd[s+1] <= dv_dvd[s] << 1;
                dv_q[s+1]   <= {dv_q[s][DIVD_W-2:0], ge};
                dv_sup[s+1] <= dv_sup[s];
            end
        end
    end

    // classify
    logic [DIVD_W-1:0]       x_full;
    logic                    c_high, c_low;
    logic [TABLE_POINTS-1:0] gt;
    logic [IDX_W-1:0]        c_seg;

    assign x_full = dv_q[DIVD_W];
    assign c_high = (dv_sup[DIVD_W] == '0) ||
                    (x_full >= DIVD_W'(pt_q(IDX_W'(TABLE_POINTS - 1))));
    assign c_low  = !c_high && (x_full <= DIVD_W'(pt_q(IDX_W'(0))));

    always_comb begin
        gt = '0;
        for (int k = 1; k < TABLE_POINTS - 1; k++) begin
            gt[k] = x_full > DIVD_W'(pt_q(IDX_W'(k)));
        end
        c_seg = IDX_W'($countones(gt));
    end

    logic             r_c_vld, r_c_low, r_c_high;
    logic [IDX_W-1:0] r_c_seg;
    logic [PT_W-1:0]  r_c_x;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_vld <= 1'b0;
        end else if (i_en) begin
            r_c_vld <= dv_vld[DIVD_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_c_low  <= c_low;
            r_c_high <= c_high;
            r_c_seg  <= c_seg;
            r_c_x    <= PT_W'(x_full);
        end
    end

    // build the queue entry: clamped words divide 0 by 1
    logic [PT_W-1:0] a0, a1, diff;
    logic            clamp;

    assign clamp = r_c_low || r_c_high;
    assign a0    = pt_q(r_c_seg);
    assign a1    = pt_q(IDX_W'(r_c_seg + 1'b1));
    assign diff  = r_c_x - a0;

    assign o_last_vld   = r_c_vld;
    assign o_entry.num  = clamp ? '0 : NUM_W'(diff) * NUM_W'(STEP_Q8);
    assign o_entry.den  = clamp ? PT_W'(1) : a1 - a0;
    assign o_entry.base = r_c_low ? TEMP_LOW : (r_c_high ? TEMP_HIGH : seg_temp(r_c_seg));
    assign o_entry.low  = r_c_low;
    assign o_entry.high = r_c_high;

endmodule

[rtl/core/nli_queue.sv]
// Small FIFO between front and back end.
// Depends on nli_pkg.
module nli_queue import nli_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_push,
    input  t_q_entry i_entry,
    input  logic     i_pop,
    output logic     o_full,
    output logic     o_nonempty,
    output t_q_entry o_head
);

    t_q_entry       r_mem [Q_DEPTH];
    logic [QP_W-1:0] r_wp, r_rp;
    logic [QP_W:0]   r_cnt;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= r_wp + 1'b1;
            if (i_pop)  r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + (QP_W+1)'(i_push) - (QP_W+1)'(i_pop);
        end
    end

    assign o_full     = r_cnt == (QP_W+1)'(Q_DEPTH);
    assign o_nonempty = r_cnt != '0;
    assign o_head     = r_mem[r_rp];

endmodule

[rtl/core/nli_back.sv]
// Back end: pipelined segment divider and output register.
// Depends on nli_pkg.
module nli_back import nli_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_en,
    input  logic      i_valid,
    input  t_q_entry  i_entry,
    output logic      o_valid,
    output t_out_word o_word
);

    logic                     dv_vld  [Q2_W+1];
    logic [PT_W-1:0]          dv_rem  [Q2_W+1];
    logic [Q2_W-1:0]          dv_dvd  [Q2_W+1];
    logic [Q2_W-1:0]          dv_q    [Q2_W+1];
    logic [PT_W-1:0]          dv_den  [Q2_W+1];
    logic signed [TEMP_W-1:0] dv_base [Q2_W+1];
    logic                     dv_low  [Q2_W+1];
    logic                     dv_high [Q2_W+1];

    // quotient is at most 2560, so the top bits of num start below den
    assign dv_vld[0]  = i_valid;
    assign dv_rem[0]  = i_entry.num[NUM_W-1:Q2_W];
    assign dv_dvd[0]  = i_entry.num[Q2_W-1:0];
    assign dv_q[0]    = '0;
    assign dv_den[0]  = i_entry.den;
    assign dv_base[0] = i_entry.base;
    assign dv_low[0]  = i_entry.low;
    assign dv_high[0] = i_entry.high;

    for (genvar s = 0; s < Q2_W; s++) begin : g_div
        logic [PT_W:0] trial;
        logic          ge;
        assign trial = {dv_rem[s], dv_dvd[s][Q2_W-1]};
        assign ge    = trial >= {1'b0, dv_den[s]};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                dv_vld[s+1] <= 1'b0;
            end else if (i_en) begin
                dv_vld[s+1] <= dv_vld[s];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                dv_rem[s+1]  <= ge ? PT_W'(trial - {1'b0, dv_den[s]}) : PT_W'(trial);
                dv_dvd[s+1]  <= dv_dvd[s] << 1;
                dv_q[s+1]    <= {dv_q[s][Q2_W-2:0], ge};
                dv_den[s+1]  <= dv_den[s];
                dv_base[s+1] <= dv_base[s];
                dv_low[s+1]  <= dv_low[s];
                dv_high[s+1] <= dv_high[s];
            end
        end
    end

    logic      r_out_vld;
    t_out_word r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_en) begin
            r_out_vld <= dv_vld[Q2_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_out.temperature_q8 <= dv_base[Q2_W] + $signed(TEMP_W'(dv_q[Q2_W]));
            r_out.clamped_low    <= dv_low[Q2_W];
            r_out.clamped_high   <= dv_high[Q2_W];
        end
    end

    assign o_valid = r_out_vld;
    assign o_word  = r_out;

endmodule

[rtl/core/ntc_lut_interpolator.sv]
// Top level of the thermistor table interpolator.
// Depends on nli_pkg, nli_front, nli_queue, nli_back.
//
// Input channel: i_valid / o_stall with word i_in_word (ADC count, supply in mV).
// Output channel: o_valid / i_stall with word o_out_word (temperature in
// 1/256 degree plus low/high clamp flags). A word moves when valid is high
// and stall is low.
// Config: i_cfg_valid / o_cfg_ready write the nominal reference in mV;
// ready is always high. Write only while the block is empty.
// Throughput: one word per cycle while neither stall is asserted. Path with no stall:
// product register, 29-stage count/supply divider, classify register,
// queue, 12-stage segment divider, output register.
// The front (multiply, divide, classify) and back (segment divide) each
// advance as a whole; a 4-entry queue sits between them. When i_stall holds
// the output, the back freezes and the queue fills; once the queue is full
// with a word waiting at the front end, the front freezes and o_stall rises.
// Reset (synchronous, active low) empties all stages and the queue and
// sets the reference to 3300 mV.
module ntc_lut_interpolator import nli_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_stall,
    input  t_in_word         i_in_word,
    output logic             o_valid,
    input  logic             i_stall,
    output t_out_word        o_out_word,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [REF_W-1:0] i_cfg_data
);

    logic [REF_W-1:0] r_nom_ref;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nom_ref <= REF_RESET;
        end else if (i_cfg_valid) begin
            r_nom_ref <= i_cfg_data;
        end
    end
    assign o_cfg_ready = 1'b1;

    logic     front_en, front_last_vld, q_full, q_nonempty, back_en, pop, push;
    t_q_entry front_entry, q_head;

    // front stalls only when its last stage holds a word the queue can't take
    assign front_en = !(front_last_vld && q_full);
    assign push     = front_last_vld && front_en;
    assign o_stall  = !front_en;

    // back advances unless the output register is full and held
    assign back_en = !(o_valid && i_stall);
    assign pop     = q_nonempty && back_en;

    nli_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (front_en),
        .i_valid    (i_valid),
        .i_word     (i_in_word),
        .i_nom_ref  (r_nom_ref),
        .o_last_vld (front_last_vld),
        .o_entry    (front_entry)
    );

    nli_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_entry    (front_entry),
        .i_pop      (pop),
        .o_full     (q_full),
        .o_nonempty (q_nonempty),
        .o_head     (q_head)
    );

    nli_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (back_en),
        .i_valid (pop),
        .i_entry (q_head),
        .o_valid (o_valid),
        .o_word  (o_out_word)
    );

endmodule

[rtl/core/nli_checker.sv]
// Port-level checker for the thermistor table interpolator, bound to the top level.
// Depends on nli_pkg and ntc_lut_interpolator.
module nli_checker import nli_pkg::*; (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      o_valid,
    input logic      i_stall,
    input t_out_word o_out_word
);

    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid)
        else $error("output word dropped under stall");

    a_flags_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_out_word.clamped_low && o_out_word.clamped_high))
        else $error("both clamp flags set");

    a_low_temp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_out_word.clamped_low |-> o_out_word.temperature_q8 == TEMP_LOW)
        else $error("low clamp with wrong temperature");

    a_high_temp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_out_word.clamped_high |-> o_out_word.temperature_q8 == TEMP_HIGH)
        else $error("high clamp with wrong temperature");

endmodule

bind ntc_lut_interpolator nli_checker u_nli_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_valid    (o_valid),
    .i_stall    (i_stall),
    .o_out_word (o_out_word)
);
